// ===== sv/u8t_pkg.sv =====
// Package for the 8N1 UART transceiver: word layouts, phase codes and
// status structs shared by the transmit, receive and top-level modules.
// No dependencies.
package u8t_pkg;

    // Input word layout, lowest bit first
    localparam int unsigned InWidth      = 16;
    localparam int unsigned InClkBit     = 0;
    localparam int unsigned InRxBit      = 1;
    localparam int unsigned InValidBit   = 2;
    localparam int unsigned InByteLo     = 3;

    // Result word layout, lowest bit first
    localparam int unsigned OutWidth     = 16;

    localparam int unsigned DivWidth     = 16;
    localparam logic [DivWidth-1:0] DivReset = 16'd16;

    // Phase codes: idle, start bit, data bits, stop bit, return to idle
    localparam logic [3:0] PhIdle      = 4'd0;
    localparam logic [3:0] PhStart     = 4'd1;
    localparam logic [3:0] PhFirstData = 4'd2;
    localparam logic [3:0] PhLastData  = 4'd9;
    localparam logic [3:0] PhStop      = 4'd10;
    localparam logic [3:0] PhDone      = 4'd11;

    localparam logic [7:0] RxMsb = 8'h80;

    // Transmitter status for the current word
    typedef struct packed {
        logic level;
        logic taken;
    } tx_stat_t;

    // Receiver status for the current word
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       serr;
    } rx_stat_t;

endpackage

// ===== sv/u8t_tx.sv =====
// Transmit side of the 8N1 UART: phase, bit counter, holding byte and line level.
// Depends on u8t_pkg.
module u8t_tx (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic                         host_valid,
    input  logic [7:0]                   host_byte,
    input  logic [u8t_pkg::DivWidth-1:0] divisor,
    output u8t_pkg::tx_stat_t            stat
);

    logic [3:0]                   phase_reg, phase_next;
    logic [u8t_pkg::DivWidth-1:0] count_reg, count_next;
    logic [7:0]                   hold_reg, hold_next;
    logic                         level_reg, level_next;
    logic                         taken;
    logic [u8t_pkg::DivWidth-1:0] count_inc;
    logic [3:0]                   phase_inc;
    logic [2:0]                   bit_idx;

    assign count_inc = count_reg + 1'b1;
    assign phase_inc = phase_reg + 1'b1;
    assign bit_idx   = 3'(phase_inc - u8t_pkg::PhFirstData);

    // Next state for one rising edge of the sampled clock.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        level_next = level_reg;
        taken      = 1'b0;
        if (step_en) begin
            if (phase_reg == u8t_pkg::PhIdle) begin
                if (host_valid) begin
                    hold_next  = host_byte;
                    phase_next = u8t_pkg::PhStart;
                    count_next = '0;
                    level_next = 1'b0;
                    taken      = 1'b1;
                end
            end else if (count_inc == divisor) begin
                count_next = '0;
                phase_next = phase_inc;
                if (phase_inc >= u8t_pkg::PhFirstData && phase_inc <= u8t_pkg::PhLastData) begin
                    level_next = hold_reg[bit_idx];
                end else if (phase_inc == u8t_pkg::PhStop) begin
                    level_next = 1'b1;
                end else begin
                    // Past the stop bit, or a wrapped code: back to idle.
                    phase_next = u8t_pkg::PhIdle;
                    level_next = 1'b1;
                end
            end else begin
                count_next = count_inc;
            end
        end
    end

    // Control state is reset; the holding byte is only read after a load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= u8t_pkg::PhIdle;
            count_reg <= '0;
            level_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    assign stat.level = level_next;
    assign stat.taken = taken;

endmodule

// ===== sv/u8t_rx.sv =====
// Receive side of the 8N1 UART: start detection, mid-bit sampling, shifter
// and stop bit check. Depends on u8t_pkg.
module u8t_rx (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic                         rx_line,
    input  logic [u8t_pkg::DivWidth-1:0] divisor,
    output u8t_pkg::rx_stat_t            stat
);

    logic [3:0]                   phase_reg, phase_next;
    logic [u8t_pkg::DivWidth-1:0] count_reg, count_next;
    logic [7:0]                   shift_reg, shift_next;

    // Next state and delivery for one rising edge of the sampled clock.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        stat       = '0;
        if (step_en) begin
            if (phase_reg == u8t_pkg::PhIdle) begin
                if (!rx_line) begin
                    // Start centring on the middle of the start bit.
                    count_next = divisor >> 1;
                    phase_next = u8t_pkg::PhStart;
                    shift_next = '0;
                end
            end else if (count_reg == divisor) begin
                count_next = '0;
                if (phase_reg == u8t_pkg::PhStart) begin
                    phase_next = rx_line ? u8t_pkg::PhIdle : u8t_pkg::PhFirstData;
                end else if (phase_reg <= u8t_pkg::PhLastData) begin
                    shift_next = (shift_reg >> 1) | (rx_line ? u8t_pkg::RxMsb : 8'h00);
                    phase_next = phase_reg + 1'b1;
                end else if (phase_reg == u8t_pkg::PhStop) begin
                    if (!rx_line) begin
                        // Low stop bit: flag it and look again one bit later.
                        stat.serr = 1'b1;
                    end else begin
                        stat.valid = 1'b1;
                        stat.data  = shift_reg;
                        phase_next = u8t_pkg::PhIdle;
                    end
                end else begin
                    phase_next = u8t_pkg::PhIdle;
                end
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= u8t_pkg::PhIdle;
            count_reg <= '0;
            shift_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== sv/uart_8n1_transceiver.sv =====
// Top level of the 8N1 UART transceiver: input register, edge detect,
// result register and divisor register. Depends on u8t_pkg, u8t_tx, u8t_rx.
//
// Usage: each input word on s_ is one sample of a slow clock together with
// the receive line and an optional byte offered for transmission. Work is
// done only when the sampled clock rises. Each input word gives exactly one
// result word on m_, carrying the transmit line level, whether the offered
// byte was taken, a received byte with its valid flag and a stop error flag.
// Path: a word accepted on s_ passes through the input register, is processed
// and lands in the result register that drives m_.
// Throughput: one word every cycle while m_tready stays high; an empty input
// register takes a new word while a finished result waits in the output
// register, and a word moves on whenever that register is empty or being emptied.
// When m_tready is low the output register holds, then the input register
// fills and s_tready drops; no word is lost and the UART state stands still.
// Reset (aresetn low, synchronous) empties both registers, sets the divisor
// to 16, puts both sides idle and drives the transmit line high.
// The divisor is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module uart_8n1_transceiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] clock_level, [1] rx_line, [2] host_valid, [10:3] host_byte, [15:11] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] tx_line, [1] host_taken, [2] rx_valid, [10:3] rx_byte, [11] stop_error,
    // [15:12] zero
    output logic [15:0] m_tdata
);

    logic                         in_valid_reg;
    logic [u8t_pkg::InWidth-1:0]  in_data_reg;
    logic                         out_valid_reg;
    logic [u8t_pkg::OutWidth-1:0] out_data_reg, out_data_next;
    logic [u8t_pkg::DivWidth-1:0] div_reg;
    logic                         prev_clk_reg;
    logic                         advance;
    logic                         rise;
    logic                         step_en;
    logic                         clk_lvl;
    u8t_pkg::tx_stat_t            tx_stat;
    u8t_pkg::rx_stat_t            rx_stat;

    // A word moves from the input register to the result register.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign clk_lvl = in_data_reg[u8t_pkg::InClkBit];
    assign rise    = clk_lvl && !prev_clk_reg;
    assign step_en = advance && rise;

    u8t_tx u_tx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .host_valid (in_data_reg[u8t_pkg::InValidBit]),
        .host_byte  (in_data_reg[u8t_pkg::InByteLo +: 8]),
        .divisor    (div_reg),
        .stat       (tx_stat)
    );

    u8t_rx u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_line (in_data_reg[u8t_pkg::InRxBit]),
        .divisor (div_reg),
        .stat    (rx_stat)
    );

    // Pack the result word.
    assign out_data_next = {4'b0000, rx_stat.serr, rx_stat.data, rx_stat.valid,
                            tx_stat.taken, tx_stat.level};

    // Input register, edge history, result register and divisor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_clk_reg  <= 1'b1;
            div_reg       <= u8t_pkg::DivReset;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                prev_clk_reg  <= clk_lvl;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                div_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 8N1 UART transceiver: drives sampled clock,
// receive line and host bytes as stream words and checks every result word against
// a cycle-free UART model or fixed expectations; depends on u8t_pkg, uart_8n1_transceiver.
module tb_top;

    // One input word, lowest bit first: clock, rx line, host valid, host byte
    typedef struct packed {
        logic [7:0] host_byte;
        logic       host_valid;
        logic       rx_line;
        logic       clock_level;
    } sample_t;

    // One result word, lowest bit first
    typedef struct packed {
        logic       stop_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       host_taken;
        logic       tx_line;
    } line_out_t;

    // A stretch of constant receive line level, counted in clock edges
    typedef struct packed {
        logic        level;
        int unsigned edges;
    } line_run_t;

    // Directed word; fixed expectations only carry tx_line and host_taken
    typedef struct packed {
        logic       clk;
        logic       rx;
        logic       hv;
        logic [7:0] hbyte;
        logic       fixed;
        logic       tx;
        logic       taken;
    } directed_word_t;

    localparam int unsigned HoldOffCycles = 300;

    localparam directed_word_t DirectedWords [16] = '{
        // no edge straight after reset: offer ignored, line idle high
        '{1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
        // first rising edge takes the byte and drives the start bit
        '{1'b1, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b0, 1'b1},
        // clock held high: nothing happens
        '{1'b1, 1'b0, 1'b1, 8'h5A, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0},
        // transmitter busy, so the offer is ignored; receiver sees a start
        '{1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 8'h7F, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'h55, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b1, 8'hAA, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
    };

    // Divisor settings walked in rising order, so no counter ever has to wrap
    localparam logic [15:0] PhaseDivisor [5] = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd65535};
    localparam int unsigned PhaseWords [5] = '{330, 330, 330, 330, 40};

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // Model state of the UART
    logic [15:0] baud_div;
    logic        last_clk;
    logic [3:0]  tx_ph;
    logic [15:0] tx_cnt;
    logic [7:0]  tx_data;
    logic        tx_out;
    logic [3:0]  rx_ph;
    logic [15:0] rx_cnt;
    logic [7:0]  rx_acc;

    line_out_t   due_outputs [$];
    line_run_t   rx_plan [$];
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    bit          steady = 1'b0;
    bit          hold_off_req = 1'b0;

    uart_8n1_transceiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Generous bound on the whole run
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Advances the UART model by one sample and returns the word it shows.
    function automatic line_out_t next_line_outputs(input sample_t smp);
        line_out_t r;
        r = '0;
        if (smp.clock_level && !last_clk) begin
            // Transmitter: take a byte when idle, otherwise count out the bit
            if (tx_ph == u8t_pkg::PhIdle) begin
                if (smp.host_valid) begin
                    tx_data = smp.host_byte;
                    tx_ph = u8t_pkg::PhStart;
                    tx_cnt = '0;
                    tx_out = 1'b0;
                    r.host_taken = 1'b1;
                end
            end else begin
                tx_cnt = tx_cnt + 16'd1;
                if (tx_cnt == baud_div) begin
                    tx_cnt = '0;
                    tx_ph = tx_ph + 4'd1;
                    if (tx_ph >= u8t_pkg::PhFirstData && tx_ph <= u8t_pkg::PhLastData) begin
                        tx_out = tx_data[tx_ph - u8t_pkg::PhFirstData];
                    end else if (tx_ph == u8t_pkg::PhStop) begin
                        tx_out = 1'b1;
                    end else if (tx_ph >= u8t_pkg::PhDone || tx_ph == u8t_pkg::PhIdle) begin
                        tx_ph = u8t_pkg::PhIdle;
                        tx_out = 1'b1;
                    end
                end
            end

            // Receiver: half-bit offset on start, then one sample per bit
            if (rx_ph == u8t_pkg::PhIdle) begin
                if (!smp.rx_line) begin
                    rx_cnt = baud_div >> 1;
                    rx_ph = u8t_pkg::PhStart;
                    rx_acc = '0;
                end
            end else if (rx_cnt == baud_div) begin
                if (rx_ph == u8t_pkg::PhStart) begin
                    rx_ph = smp.rx_line ? u8t_pkg::PhIdle : u8t_pkg::PhFirstData;
                end else if (rx_ph <= u8t_pkg::PhLastData) begin
                    rx_acc = {smp.rx_line, rx_acc[7:1]};
                    rx_ph = rx_ph + 4'd1;
                end else if (rx_ph == u8t_pkg::PhStop) begin
                    if (!smp.rx_line) begin
                        r.stop_error = 1'b1;
                    end else begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = rx_acc;
                        rx_ph = u8t_pkg::PhIdle;
                    end
                end else begin
                    rx_ph = u8t_pkg::PhIdle;
                end
                rx_cnt = '0;
            end else begin
                rx_cnt = rx_cnt + 16'd1;
            end
        end
        last_clk = smp.clock_level;
        r.tx_line = tx_out;
        return r;
    endfunction

    // Offers one word, with random gaps, and records its expected result once taken.
    task automatic offer(input sample_t smp, input logic fixed, input line_out_t want);
        line_out_t predicted;
        while (!steady && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, smp};
        do @(posedge aclk); while (!s_tready);
        predicted = next_line_outputs(smp);
        due_outputs.push_back(fixed ? want : predicted);
        words_sent++;
        @(negedge aclk);
    endtask

    function automatic sample_t random_sample(input logic clk, input bit quiet);
        sample_t smp;
        smp.clock_level = clk;
        smp.rx_line = quiet ? 1'b1 : 1'($urandom_range(1));
        smp.host_valid = quiet ? 1'b0 : ($urandom_range(99) < 40);
        smp.host_byte = 8'($urandom);
        return smp;
    endfunction

    // One slow clock period: low samples, the rising sample carrying the line
    // level, and now and then a repeated high sample that is not an edge.
    task automatic drive_clock_edge(input logic edge_rx, input bit quiet);
        sample_t smp;
        int unsigned lows;
        lows = ($urandom_range(4) == 0) ? 2 : 1;
        repeat (lows) offer(random_sample(1'b0, quiet), 1'b0, '0);
        smp = random_sample(1'b1, quiet);
        smp.rx_line = edge_rx;
        offer(smp, 1'b0, '0);
        if (!quiet && $urandom_range(4) == 0) offer(random_sample(1'b1, quiet), 1'b0, '0);
    endtask

    // Writes the divisor once every expected word has come back.
    task automatic set_divisor(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        baud_div = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge aclk) begin : result_check
        line_out_t want;
        line_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = line_out_t'(m_tdata[11:0]);
            if (due_outputs.size() == 0) begin
                $error("result word %h with nothing expected", m_tdata);
                mismatches++;
            end else begin
                want = due_outputs.pop_front();
                check_field("tx_line", {7'd0, want.tx_line}, {7'd0, got.tx_line});
                check_field("host_taken", {7'd0, want.host_taken}, {7'd0, got.host_taken});
                check_field("rx_valid", {7'd0, want.rx_valid}, {7'd0, got.rx_valid});
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("stop_error", {7'd0, want.stop_error}, {7'd0, got.stop_error});
                check_field("padding", 8'd0, {4'd0, m_tdata[15:12]});
            end
        end
    end

    // Receiver side: random stalls, one long hold-off on request
    initial begin
        int unsigned held;
        held = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                held++;
                if (held == HoldOffCycles) hold_off_req = 1'b0;
            end else if (!steady && $urandom_range(99) < 37) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        sample_t     smp;
        line_out_t   want;
        line_run_t   run;
        int unsigned first;
        int unsigned bit_len;
        int unsigned kind;
        int unsigned pieces;
        logic [7:0]  frame_byte;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;

        baud_div = u8t_pkg::DivReset;
        last_clk = 1'b1;
        tx_ph = u8t_pkg::PhIdle;
        tx_cnt = '0;
        tx_data = '0;
        tx_out = 1'b1;
        rx_ph = u8t_pkg::PhIdle;
        rx_cnt = '0;
        rx_acc = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset divisor
        foreach (DirectedWords[i]) begin
            smp.clock_level = DirectedWords[i].clk;
            smp.rx_line = DirectedWords[i].rx;
            smp.host_valid = DirectedWords[i].hv;
            smp.host_byte = DirectedWords[i].hbyte;
            want = '0;
            want.tx_line = DirectedWords[i].tx;
            want.host_taken = DirectedWords[i].taken;
            offer(smp, DirectedWords[i].fixed, want);
        end

        // Quiet line until both directions are surely idle again
        repeat (12 * (32'(baud_div) + 1) + 4) drive_clock_edge(1'b1, 1'b1);

        foreach (PhaseDivisor[p]) begin
            set_divisor(PhaseDivisor[p]);
            steady = (p == 2);
            if (p == 1) hold_off_req = 1'b1;
            first = words_sent;
            while (words_sent - first < PhaseWords[p]) begin
                // Plan more receive traffic, mostly clean frames. Each bit is held for
                // bit_len, and the start bit is stretched so that the mid-bit samples land.
                if (rx_plan.size() == 0) begin
                    bit_len = 32'(baud_div) + 1;
                    kind = $urandom_range(9);
                    frame_byte = 8'($urandom);
                    if (kind == 8) begin
                        // false start: low for at most half a bit
                        rx_plan.push_back('{1'b0, $urandom_range(
                            32'(baud_div) - 32'(baud_div >> 1), 1)});
                        rx_plan.push_back('{1'b1, bit_len});
                    end else if (kind == 9) begin
                        // noise, then a long idle so the receiver recovers
                        pieces = $urandom_range(4, 1);
                        repeat (pieces) rx_plan.push_back('{1'($urandom_range(1)),
                            $urandom_range(2 * bit_len, 1)});
                        rx_plan.push_back('{1'b1, 11 * bit_len + 2});
                    end else begin
                        rx_plan.push_back('{1'b0, bit_len + 1});
                        for (int b = 0; b < 8; b++) rx_plan.push_back('{frame_byte[b], bit_len});
                        // a low stop bit now and then, held for up to three bits
                        if (kind == 7) begin
                            rx_plan.push_back('{1'b0, $urandom_range(3 * bit_len, 1)});
                        end
                        rx_plan.push_back('{1'b1, bit_len + $urandom_range(3)});
                    end
                end
                run = rx_plan.pop_front();
                if (run.edges > 1) begin
                    run.edges = run.edges - 1;
                    rx_plan.push_front(run);
                end
                drive_clock_edge(run.level, 1'b0);
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
